/* sv/periodic_task_release_table_defines.svh */
// Assertion macros for the periodic task release table.
`ifndef PERIODIC_TASK_RELEASE_TABLE_DEFINES_SVH
`define PERIODIC_TASK_RELEASE_TABLE_DEFINES_SVH

// Same-cycle implication, disabled in reset.
`define PRT_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("prt assertion failed");

// Next-cycle implication, disabled in reset.
`define PRT_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("prt assertion failed");

`endif

/* sv/prt_pkg.sv */
`default_nettype none
package prt_pkg;

  localparam int MAX_TASKS = 16;
  localparam int IDX_W     = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
  localparam int CNT_W     = $clog2(MAX_TASKS + 1);

  localparam logic [1:0] MODE_TICK     = 2'd0;
  localparam logic [1:0] MODE_CREATE   = 2'd1;
  localparam logic [1:0] MODE_DELETE   = 2'd2;
  localparam logic [1:0] MODE_DISPATCH = 2'd3;

  typedef enum logic [1:0] {
    ST_WAITING = 2'd0,
    ST_READY   = 2'd1,
    ST_RUNNING = 2'd2,
    ST_DELETED = 2'd3
  } task_status_t;

  typedef enum logic [1:0] {
    FSM_IDLE,
    FSM_SCAN,
    FSM_FIN
  } fsm_state_t;

  typedef struct packed {
    logic [15:0]  handle;
    logic [7:0]   prio;
    logic [15:0]  period;
    logic [15:0]  next_release;
    task_status_t status;
  } entry_t;

  typedef struct packed {
    logic [1:0]  mode;
    logic [15:0] handle;
    logic [7:0]  prio;
    logic [15:0] period;
    logic [15:0] first;
  } op_t;

  // Per-step context seen by the update unit at the head of the ring.
  typedef struct packed {
    logic [IDX_W-1:0] idx;
    logic [CNT_W-1:0] used_count;
    logic [15:0]      tick;
    logic [7:0]       max_prio;
    logic             hit;
  } step_ctx_t;

endpackage
`default_nettype wire

/* sv/prt_cell.sv */
`default_nettype none
module prt_cell (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           shift,
  input  wire prt_pkg::entry_t ent_in,
  output prt_pkg::entry_t     ent
);

  always_ff @(posedge clk) begin
    if (rst) begin
      ent <= '{handle: '0, prio: '0, period: '0, next_release: '0,
               status: prt_pkg::ST_WAITING};
    end else if (shift) begin
      ent <= ent_in;
    end
  end

endmodule
`default_nettype wire

/* sv/prt_update.sv */
`default_nettype none
module prt_update (
  input  wire prt_pkg::op_t       op,
  input  wire prt_pkg::step_ctx_t ctx,
  input  wire prt_pkg::entry_t    ent_in,
  output prt_pkg::entry_t         ent_out,
  output logic                    hit,
  output logic [7:0]              max_prio
);

  logic live;

  always_comb begin
    ent_out  = ent_in;
    hit      = 1'b0;
    max_prio = ctx.max_prio;
    live     = prt_pkg::CNT_W'(ctx.idx) < ctx.used_count;
    case (op.mode)
      prt_pkg::MODE_TICK: begin
        if (live && ent_in.status != prt_pkg::ST_DELETED) begin
          if (ent_in.next_release == ctx.tick) begin
            ent_out.next_release = ent_in.period + ctx.tick;
            ent_out.status       = prt_pkg::ST_READY;
            if (ent_in.prio > ctx.max_prio) begin
              max_prio = ent_in.prio;
            end
          end else begin
            ent_out.status = prt_pkg::ST_WAITING;
          end
        end
      end
      prt_pkg::MODE_CREATE: begin
        // idx never reaches MAX_TASKS, so a full table never matches;
        // used_count moves with idx after the write, so only the first match counts
        if (!ctx.hit && prt_pkg::CNT_W'(ctx.idx) == ctx.used_count) begin
          ent_out.handle       = op.handle;
          ent_out.prio         = op.prio;
          ent_out.period       = op.period;
          ent_out.next_release = op.first;
          ent_out.status       = prt_pkg::ST_WAITING;
          hit                  = 1'b1;
        end
      end
      prt_pkg::MODE_DELETE: begin
        if (live && ent_in.status != prt_pkg::ST_DELETED &&
            ent_in.handle == op.handle) begin
          ent_out.handle       = '0;
          ent_out.prio         = '0;
          ent_out.period       = '0;
          ent_out.next_release = '0;
          ent_out.status       = prt_pkg::ST_DELETED;
          hit                  = 1'b1;
        end
      end
      prt_pkg::MODE_DISPATCH: begin
        if (live && !ctx.hit && ent_in.status == prt_pkg::ST_READY &&
            ent_in.prio <= 8'(prt_pkg::MAX_TASKS)) begin
          ent_out.status = prt_pkg::ST_RUNNING;
          hit            = 1'b1;
        end
      end
      default: begin
        hit = 1'b0;
      end
    endcase
  end

endmodule
`default_nettype wire

/* sv/periodic_task_release_table.sv */
// Channel | Handshake              | Payload
// --------+------------------------+------------------------------------------------
// in      | in_valid / in_stall    | mode, task_handle, task_prio, task_period,
//         |                        | first_release
// out     | out_valid / out_stall  | op_status, chosen_slot, chosen_handle,
//         |                        | ready_mask, highest_priority, tick_now
//
// Every item passes through an accept edge in IDLE, one full rotation of the entry
// ring through the update unit, and a finish cycle that loads the output register.
// The ring rotation dominates: one entry passes the head each cycle.
// Reset (rst, synchronous) clears all entries to zero/waiting and the counters.
// A stalled result sits in the output register; the next item may be accepted
// and scanned meanwhile, and its finish cycle waits until the register frees.
`default_nettype none
`include "periodic_task_release_table_defines.svh"
module periodic_task_release_table (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [1:0]  mode,
  input  wire logic [15:0] task_handle,
  input  wire logic [7:0]  task_prio,
  input  wire logic [15:0] task_period,
  input  wire logic [15:0] first_release,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             op_status,
  output logic [3:0]       chosen_slot,
  output logic [15:0]      chosen_handle,
  output logic [15:0]      ready_mask,
  output logic [7:0]       highest_priority,
  output logic [15:0]      tick_now
);

  localparam int N = prt_pkg::MAX_TASKS;
  localparam logic [prt_pkg::IDX_W-1:0] LAST_IDX = prt_pkg::IDX_W'(N - 1);

  prt_pkg::fsm_state_t state, state_next;

  // Latched request and scan bookkeeping
  prt_pkg::op_t                op;
  logic [prt_pkg::IDX_W-1:0]   idx;
  logic [prt_pkg::CNT_W-1:0]   used_count;
  logic [7:0]                  max_prio;
  logic [15:0]                 tick_count;
  logic                        hit;
  logic [prt_pkg::IDX_W-1:0]   hit_slot;
  logic [15:0]                 hit_handle;

  logic accept;
  logic shift;
  logic load_out;
  logic scan_last;

  // Ring of cells: cell k takes from cell k+1, the last cell takes the
  // updated head entry, so a full rotation puts everything back in place.
  prt_pkg::entry_t ent [N];
  prt_pkg::entry_t head_new;
  prt_pkg::step_ctx_t ctx;
  logic step_hit;
  logic [7:0] step_max;

  genvar g;
  generate
    for (g = 0; g < N; g++) begin : g_cell
      if (g == N - 1) begin : g_tail
        prt_cell u_cell (
          .clk   (clk),
          .rst   (rst),
          .shift (shift),
          .ent_in(head_new),
          .ent   (ent[g])
        );
      end else begin : g_mid
        prt_cell u_cell (
          .clk   (clk),
          .rst   (rst),
          .shift (shift),
          .ent_in(ent[g+1]),
          .ent   (ent[g])
        );
      end
    end
  endgenerate

  assign ctx = '{idx: idx, used_count: used_count, tick: tick_count,
                 max_prio: max_prio, hit: hit};

  prt_update u_update (
    .op      (op),
    .ctx     (ctx),
    .ent_in  (ent[0]),
    .ent_out (head_new),
    .hit     (step_hit),
    .max_prio(step_max)
  );

  assign accept    = in_valid && !in_stall;
  assign scan_last = (state == prt_pkg::FSM_SCAN) && (idx == LAST_IDX);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      prt_pkg::FSM_IDLE: begin
        if (in_valid) begin
          state_next = prt_pkg::FSM_SCAN;
        end
      end
      prt_pkg::FSM_SCAN: begin
        if (idx == LAST_IDX) begin
          state_next = prt_pkg::FSM_FIN;
        end
      end
      prt_pkg::FSM_FIN: begin
        if (!out_valid || !out_stall) begin
          state_next = prt_pkg::FSM_IDLE;
        end
      end
      default: begin
        state_next = prt_pkg::FSM_IDLE;
      end
    endcase
  end

  // Control outputs
  always_comb begin
    in_stall = 1'b1;
    shift    = 1'b0;
    load_out = 1'b0;
    case (state)
      prt_pkg::FSM_IDLE: begin
        in_stall = 1'b0;
      end
      prt_pkg::FSM_SCAN: begin
        shift = 1'b1;
      end
      prt_pkg::FSM_FIN: begin
        load_out = !out_valid || !out_stall;
      end
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= prt_pkg::FSM_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Request latch and scan state
  always_ff @(posedge clk) begin
    if (rst) begin
      idx        <= '0;
      used_count <= '0;
      max_prio   <= '0;
      tick_count <= '0;
      hit        <= 1'b0;
    end else if (accept) begin
      idx <= '0;
      hit <= 1'b0;
    end else if (shift) begin
      idx      <= idx + 1'b1;
      max_prio <= step_max;
      if (step_hit) begin
        hit <= 1'b1;
        if (op.mode == prt_pkg::MODE_CREATE) begin
          used_count <= used_count + 1'b1;
        end
      end
      if (scan_last && op.mode == prt_pkg::MODE_TICK) begin
        tick_count <= tick_count + 16'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op <= '{mode: mode, handle: task_handle, prio: task_prio,
              period: task_period, first: first_release};
    end
    // first hit wins; later delete hits do not matter for the result
    if (shift && step_hit && !hit) begin
      hit_slot   <= idx;
      hit_handle <= ent[0].handle;
    end
  end

  // Ready mask from the settled ring, slots 0 to 15 only
  logic [15:0] mask_now;
  generate
    for (g = 0; g < 16; g++) begin : g_mask
      if (g < N) begin : g_on
        assign mask_now[g] = (ent[g].status == prt_pkg::ST_READY);
      end else begin : g_off
        assign mask_now[g] = 1'b0;
      end
    end
  endgenerate

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      op_status        <= (op.mode == prt_pkg::MODE_TICK) ? 1'b0 : !hit;
      chosen_slot      <= (hit && (op.mode == prt_pkg::MODE_CREATE ||
                                   op.mode == prt_pkg::MODE_DISPATCH)) ?
                          4'(hit_slot) : 4'd0;
      chosen_handle    <= (hit && op.mode == prt_pkg::MODE_DISPATCH) ?
                          hit_handle : 16'd0;
      ready_mask       <= mask_now;
      highest_priority <= max_prio;
      tick_now         <= tick_count;
    end
  end

  `PRT_ASSERT_NEXT(a_accept_starts_scan, clk, rst, accept,
                   state == prt_pkg::FSM_SCAN && idx == '0)
  `PRT_ASSERT_NEXT(a_scan_ends_in_fin, clk, rst, scan_last,
                   state == prt_pkg::FSM_FIN)
  `PRT_ASSERT_IMPL(a_no_accept_in_scan, clk, rst, state == prt_pkg::FSM_SCAN,
                   in_stall)
  `PRT_ASSERT_IMPL(a_used_in_range, clk, rst, 1'b1,
                   used_count <= prt_pkg::CNT_W'(N))

endmodule
`default_nettype wire

/* tb/testbench.sv */
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // Hard stop, several times the slowest legal run.
  localparam int RUN_LIMIT_NS = 8_000_000;
  // Cycles to watch for stray results once every expectation has been met.
  localparam int TAIL_CYCLES  = 4 * (prt_pkg::MAX_TASKS + 2);
  localparam int RANDOM_ITEMS = 950;

  // One request as the sender sees it; hold_for_drain makes the driver wait
  // until every earlier result has come back before presenting it.
  typedef struct {
    logic [1:0]  op;
    logic [15:0] handle;
    logic [7:0]  prio;
    logic [15:0] period;
    logic [15:0] due;
    bit          hold_for_drain;
  } job_item_t;

  typedef struct {
    logic        fail;
    logic [3:0]  slot;
    logic [15:0] handle;
    logic [15:0] ready;
    logic [7:0]  peak;
    logic [15:0] tick;
  } table_result_t;

  logic        clk;
  logic        rst           = 1'b1;
  logic        in_valid      = 1'b0;
  logic        in_stall;
  logic [1:0]  mode          = prt_pkg::MODE_TICK;
  logic [15:0] task_handle   = '0;
  logic [7:0]  task_prio     = '0;
  logic [15:0] task_period   = '0;
  logic [15:0] first_release = '0;
  logic        out_valid;
  logic        out_stall     = 1'b0;
  logic        op_status;
  logic [3:0]  chosen_slot;
  logic [15:0] chosen_handle;
  logic [15:0] ready_mask;
  logic [7:0]  highest_priority;
  logic [15:0] tick_now;

  periodic_task_release_table u_top (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Shadow copy of the task table, advanced once per accepted item.
  // ---------------------------------------------------------------------
  logic [15:0]           slot_handle [prt_pkg::MAX_TASKS];
  logic [7:0]            slot_prio   [prt_pkg::MAX_TASKS];
  logic [15:0]           slot_period [prt_pkg::MAX_TASKS];
  logic [15:0]           slot_due    [prt_pkg::MAX_TASKS];
  prt_pkg::task_status_t slot_state  [prt_pkg::MAX_TASKS];
  int                    slots_used  = 0;
  logic [7:0]            peak_prio   = '0;
  logic [15:0]           tick_ctr    = '0;

  // What the run actually exercised, for the summary.
  int n_ticks = 0, n_releases = 0, n_creates = 0, n_full = 0;
  int n_deletes = 0, n_del_miss = 0, n_dispatch = 0, n_disp_empty = 0;

  initial begin
    for (int i = 0; i < prt_pkg::MAX_TASKS; i++) begin
      slot_handle[i] = '0;
      slot_prio[i]   = '0;
      slot_period[i] = '0;
      slot_due[i]    = '0;
      slot_state[i]  = prt_pkg::ST_WAITING;
    end
  end

  function automatic table_result_t table_step(input job_item_t j);
    table_result_t r;
    bit            hit;
    r.fail   = 1'b0;
    r.slot   = '0;
    r.handle = '0;
    r.ready  = '0;
    hit      = 1'b0;
    case (j.op)
      prt_pkg::MODE_TICK: begin
        n_ticks++;
        // Deleted slots are frozen; everything else is either released
        // this tick or knocked back to waiting (running included).
        for (int i = 0; i < slots_used; i++) begin
          if (slot_state[i] == prt_pkg::ST_DELETED) continue;
          if (slot_due[i] == tick_ctr) begin
            slot_due[i]   = slot_due[i] + slot_period[i];
            slot_state[i] = prt_pkg::ST_READY;
            if (peak_prio < slot_prio[i]) peak_prio = slot_prio[i];
            n_releases++;
          end else begin
            slot_state[i] = prt_pkg::ST_WAITING;
          end
        end
        tick_ctr = tick_ctr + 16'd1;
      end
      prt_pkg::MODE_CREATE: begin
        n_creates++;
        // Append only; a deleted slot is never handed out again.
        if (slots_used < prt_pkg::MAX_TASKS) begin
          slot_handle[slots_used] = j.handle;
          slot_prio[slots_used]   = j.prio;
          slot_period[slots_used] = j.period;
          slot_due[slots_used]    = j.due;
          slot_state[slots_used]  = prt_pkg::ST_WAITING;
          r.slot = 4'(slots_used);
          slots_used++;
        end else begin
          r.fail = 1'b1;
          n_full++;
        end
      end
      prt_pkg::MODE_DELETE: begin
        n_deletes++;
        // Every live copy of the handle goes, not just the first one.
        for (int i = 0; i < slots_used; i++) begin
          if (slot_state[i] != prt_pkg::ST_DELETED && slot_handle[i] == j.handle) begin
            slot_handle[i] = '0;
            slot_prio[i]   = '0;
            slot_period[i] = '0;
            slot_due[i]    = '0;
            slot_state[i]  = prt_pkg::ST_DELETED;
            hit = 1'b1;
          end
        end
        r.fail = !hit;
        if (!hit) n_del_miss++;
      end
      default: begin
        n_dispatch++;
        r.fail = 1'b1;
        // Lowest ready slot wins, but only if its priority fits the table size.
        for (int i = 0; i < slots_used; i++) begin
          if (slot_state[i] == prt_pkg::ST_READY && slot_prio[i] <= prt_pkg::MAX_TASKS) begin
            slot_state[i] = prt_pkg::ST_RUNNING;
            r.slot   = 4'(i);
            r.handle = slot_handle[i];
            r.fail   = 1'b0;
            break;
          end
        end
        if (r.fail) n_disp_empty++;
      end
    endcase
    for (int i = 0; i < slots_used && i < 16; i++)
      if (slot_state[i] == prt_pkg::ST_READY) r.ready[i] = 1'b1;
    r.peak = peak_prio;
    r.tick = tick_ctr;
    return r;
  endfunction

  // Mostly back-to-back, often a short pause, now and then a long one.
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // ---------------------------------------------------------------------
  // Request generation. A rough tally of ticks and live handles lets the
  // random part aim first releases near the current tick count and aim
  // deletes at handles that are really in the table.
  // ---------------------------------------------------------------------
  job_item_t   job_q[$];
  bit          hold_next  = 1'b0;
  int          gen_ticks  = 0;
  int          gen_used   = 0;
  logic [15:0] live_handles[$];

  task automatic push_job(input logic [1:0] op, input logic [15:0] h, input logic [7:0] p,
                          input logic [15:0] per, input logic [15:0] due);
    job_item_t j;
    j.op             = op;
    j.handle         = h;
    j.prio           = p;
    j.period         = per;
    j.due            = due;
    j.hold_for_drain = hold_next;
    hold_next        = 1'b0;
    job_q.push_back(j);
    if (op == prt_pkg::MODE_TICK) gen_ticks++;
    if (op == prt_pkg::MODE_CREATE && gen_used < prt_pkg::MAX_TASKS) begin
      gen_used++;
      live_handles.push_back(h);
    end
    if (op == prt_pkg::MODE_DELETE)
      for (int i = live_handles.size() - 1; i >= 0; i--)
        if (live_handles[i] == h) live_handles.delete(i);
  endtask

  // ---------------------------------------------------------------------
  // Driver: presents queued requests, predicts each one on acceptance and
  // files the prediction under its sequence number.
  // ---------------------------------------------------------------------
  job_item_t     cur_job;
  table_result_t predicted_result [0:4095];
  int            accepted_n = 0;
  int            received_n = 0;
  int            in_gap     = 0;
  int            in_calm    = 0;
  int            n_errors   = 0;

  always @(posedge clk) begin : drive_requests
    job_item_t     nxt;
    table_result_t res;
    bit            took;
    int            gap;
    if (rst) begin
      in_valid <= 1'b0;
      in_gap   <= 0;
    end else begin
      took = in_valid && !in_stall;
      if (took) begin
        res = table_step(cur_job);
        predicted_result[accepted_n] <= res;
        accepted_n <= accepted_n + 1;
      end
      // A stalled item stays put; otherwise pick what goes out next.
      if (!in_valid || took) begin
        if (in_gap > 0) begin
          in_gap   <= in_gap - 1;
          in_valid <= 1'b0;
        end else if (job_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (job_q[0].hold_for_drain && (took || accepted_n != received_n)) begin
          in_valid <= 1'b0;
        end else begin
          nxt = job_q.pop_front();
          cur_job       <= nxt;
          mode          <= nxt.op;
          task_handle   <= nxt.handle;
          task_prio     <= nxt.prio;
          task_period   <= nxt.period;
          first_release <= nxt.due;
          in_valid      <= 1'b1;
          if (in_calm > 0) begin
            gap = 0;
            in_calm <= in_calm - 1;
          end else begin
            gap = pick_gap();
            if ($urandom_range(0, 39) == 0) in_calm <= $urandom_range(15, 50);
          end
          in_gap <= gap;
        end
      end
    end
  end

  // ---------------------------------------------------------------------
  // Monitor: random back-pressure, and an in-order field check of every
  // result against the oldest open prediction.
  // ---------------------------------------------------------------------
  int out_hold = 0;
  int out_calm = 0;

  task automatic check_field(input string what, input logic [15:0] got,
                             input logic [15:0] want);
    if (got !== want) begin
      n_errors++;
      $display("%0t: %s wrong on result %0d: expected 0x%0h, got 0x%0h",
               $time, what, received_n, want, got);
    end
  endtask

  always @(posedge clk) begin : watch_results
    table_result_t want;
    int            n;
    if (rst) begin
      out_stall <= 1'b0;
      out_hold  <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (received_n >= accepted_n) begin
          n_errors++;
          $display("%0t: result with nothing outstanding: status %0d slot %0d handle 0x%0h",
                   $time, op_status, chosen_slot, chosen_handle);
        end else begin
          want = predicted_result[received_n];
          check_field("op_status", 16'(op_status), 16'(want.fail));
          check_field("chosen_slot", 16'(chosen_slot), 16'(want.slot));
          check_field("chosen_handle", chosen_handle, want.handle);
          check_field("ready_mask", ready_mask, want.ready);
          check_field("highest_priority", 16'(highest_priority), 16'(want.peak));
          check_field("tick_now", tick_now, want.tick);
          received_n <= received_n + 1;
        end
      end
      // Stall pattern: runs of stall with lengths from pick_gap, quiet stretches in between.
      if (out_hold > 0) begin
        out_hold  <= out_hold - 1;
        out_stall <= 1'b1;
      end else if (out_calm > 0) begin
        out_calm  <= out_calm - 1;
        out_stall <= 1'b0;
      end else if ($urandom_range(0, 3) == 0) begin
        n = pick_gap();
        out_stall <= (n != 0);
        out_hold  <= (n > 0) ? n - 1 : 0;
        if ($urandom_range(0, 59) == 0) out_calm <= $urandom_range(50, 300);
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus and end of run.
  // ---------------------------------------------------------------------
  initial begin : run_stimulus
    job_item_t   j;
    int          roll;
    logic [1:0]  op;
    logic [15:0] h, per, due;
    logic [7:0]  p;

    // Directed: empty table, edge values, release wrap, duplicate handles,
    // a ready task whose priority is too high to dispatch.
    push_job(prt_pkg::MODE_DISPATCH, 16'h1234, 8'h00, 16'h0000, 16'h0000); // nothing ready
    push_job(prt_pkg::MODE_DELETE,   16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF); // handle not present
    push_job(prt_pkg::MODE_TICK,     16'h0001, 8'h00, 16'h0000, 16'h0000); // tick 0, empty table
    push_job(prt_pkg::MODE_CREATE,   16'h0001, 8'h00, 16'h0000, 16'h0001); // zero period
    push_job(prt_pkg::MODE_CREATE,   16'hFFFF, 8'hFF, 16'hFFFF, 16'h0001); // release wraps to 0
    push_job(prt_pkg::MODE_CREATE,   16'hAAAA, 8'd16, 16'h0002, 16'h0001); // priority at limit
    push_job(prt_pkg::MODE_CREATE,   16'h5555, 8'd17, 16'h0001, 16'h0002); // priority just above
    push_job(prt_pkg::MODE_CREATE,   16'hAAAA, 8'h01, 16'h0003, 16'h0001); // duplicate handle
    push_job(prt_pkg::MODE_TICK,     16'h0000, 8'h00, 16'h0000, 16'h0000); // releases 0,1,2,4
    push_job(prt_pkg::MODE_DISPATCH, 16'h0000, 8'h00, 16'h0000, 16'h0000); // slot 0
    push_job(prt_pkg::MODE_DISPATCH, 16'h0000, 8'h00, 16'h0000, 16'h0000); // slot 2, skips 255
    push_job(prt_pkg::MODE_DISPATCH, 16'h0000, 8'h00, 16'h0000, 16'h0000); // slot 4
    push_job(prt_pkg::MODE_DISPATCH, 16'h0000, 8'h00, 16'h0000, 16'h0000); // only 255 ready
    push_job(prt_pkg::MODE_TICK,     16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF); // running to waiting
    push_job(prt_pkg::MODE_DISPATCH, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF); // prio 17, refused
    push_job(prt_pkg::MODE_DELETE,   16'hAAAA, 8'h00, 16'h0000, 16'h0000); // removes both
    push_job(prt_pkg::MODE_DELETE,   16'hAAAA, 8'h00, 16'h0000, 16'h0000); // deleted never match
    push_job(prt_pkg::MODE_TICK,     16'h0000, 8'h00, 16'h0000, 16'h0000); // slot 2 due, deleted
    push_job(prt_pkg::MODE_TICK,     16'h0000, 8'h00, 16'h0000, 16'h0000);

    // Random part: mostly ticks and dispatches against a well-populated
    // table, creates aimed just ahead of the tick count, a trickle of
    // deletes. The table fills early, so refused creates show up too.
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k == 0 || k == RANDOM_ITEMS / 2) hold_next = 1'b1;
      roll = $urandom_range(0, 99);
      h    = 16'($urandom_range(1, 65535));
      p    = 8'($urandom);
      per  = 16'($urandom);
      due  = 16'($urandom);
      if (roll < 45) begin
        op = prt_pkg::MODE_TICK;
      end else if (roll < 75) begin
        op = prt_pkg::MODE_DISPATCH;
      end else if (roll < 90) begin
        op = prt_pkg::MODE_CREATE;
        if ($urandom_range(0, 4) != 0) p = 8'($urandom_range(0, 20));
        roll = $urandom_range(0, 9);
        if (roll < 7) per = 16'($urandom_range(1, 12));
        else if (roll < 8) per = '0;
        if ($urandom_range(0, 4) != 0) due = 16'(gen_ticks + $urandom_range(0, 24));
        if (live_handles.size() > 0 && $urandom_range(0, 6) == 0)
          h = live_handles[$urandom_range(0, live_handles.size() - 1)];
      end else begin
        op = prt_pkg::MODE_DELETE;
        if (live_handles.size() > 6 && $urandom_range(0, 7) == 0)
          h = live_handles[$urandom_range(0, live_handles.size() - 1)];
      end
      push_job(op, h, p, per, due);
    end

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (job_q.size() != 0 || in_valid) @(posedge clk);
    while (received_n != accepted_n) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (received_n != accepted_n) begin
      n_errors++;
      $display("%0t: %0d results never arrived", $time, accepted_n - received_n);
    end
    $display("run: %0d items, %0d ticks releasing %0d tasks, %0d creates (%0d table full)",
             accepted_n, n_ticks, n_releases, n_creates, n_full);
    $display("run: %0d deletes (%0d misses), %0d dispatches (%0d with nothing eligible)",
             n_deletes, n_del_miss, n_dispatch, n_disp_empty);
    if (n_errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

/* filelist.f */
+incdir+sv
sv/prt_pkg.sv
sv/prt_cell.sv
sv/prt_update.sv
sv/periodic_task_release_table.sv
tb/testbench.sv
